FILE: hw/rtl/ita2enc_pkg.sv
// Shared types, constants and lookup table for the ASCII to ITA2 shift encoder.
`timescale 1ns / 1ps
`default_nettype none

package ita2enc_pkg;

  localparam int unsigned CODE_W        = 5;
  localparam int unsigned COUNT_W       = 6;
  localparam int unsigned RESULTS_MAX   = 3;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam logic [COUNT_W-1:0] MAX_CODES_RST = 6'd39;
  localparam logic [COUNT_W-1:0] COUNT_MAX     = 6'd63;

  // Table entry layout: class bits over the raw 5-bit code.
  localparam int unsigned CLS_LTRS_BIT = 5;
  localparam int unsigned CLS_FIGS_BIT = 6;
  localparam int unsigned CLS_ESC_BIT  = 7;

  localparam logic [7:0]        ESCAPE_SUBST = 8'h59;
  localparam logic [CODE_W-1:0] LTRS_CODE    = 5'h1F;
  localparam logic [CODE_W-1:0] FIGS_CODE    = 5'h1B;

  typedef enum logic [1:0] {
    SHIFT_LTRS    = 2'd0,
    SHIFT_FIGS    = 2'd1,
    SHIFT_UNKNOWN = 2'd2
  } shift_t;

  typedef struct packed {
    logic [7:0] ascii_char;
    logic       end_of_write;
    logic [1:0] receive_shift;
  } in_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              refused;
    logic              last_of_run;
  } out_item_t;

  // One classified character: up to three bit-reversed codes, sent in order.
  typedef struct packed {
    logic [RESULTS_MAX-1:0][CODE_W-1:0] codes;
    logic [1:0]                         cnt;      // number of beats, 1..3
    logic                               refused;  // first beat is a refusal
  } job_t;

  localparam logic [7:0] ITA2_TAB [128] = '{
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h02,8'h00,8'h00,8'h08,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h04,8'h80,8'h80,8'h4D,8'h5A,8'h80,8'h80,8'h45,
    8'h4F,8'h52,8'h4B,8'h51,8'h4C,8'h43,8'h5C,8'h5D,
    8'h56,8'h57,8'h53,8'h41,8'h4A,8'h50,8'h55,8'h47,
    8'h46,8'h58,8'h4E,8'h80,8'h80,8'h5E,8'h80,8'h59,
    8'h54,8'h23,8'h39,8'h2E,8'h29,8'h21,8'h2D,8'h3A,
    8'h34,8'h26,8'h2B,8'h2F,8'h32,8'h3C,8'h2C,8'h38,
    8'h36,8'h37,8'h2A,8'h25,8'h30,8'h27,8'h3E,8'h33,
    8'h3D,8'h35,8'h31,8'h80,8'h80,8'h80,8'h80,8'h80,
    8'h80,8'h23,8'h39,8'h2E,8'h29,8'h21,8'h2D,8'h3A,
    8'h34,8'h26,8'h2B,8'h2F,8'h32,8'h3C,8'h2C,8'h38,
    8'h36,8'h37,8'h2A,8'h25,8'h30,8'h27,8'h3E,8'h33,
    8'h3D,8'h35,8'h31,8'h80,8'h80,8'h80,8'h80,8'h80
  };

  function automatic logic [CODE_W-1:0] rev5(input logic [CODE_W-1:0] c);
    rev5 = {c[0], c[1], c[2], c[3], c[4]};
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ita2enc_front.sv
// Front end: table lookup, shift tracking, packet count, builds one job per character.
`timescale 1ns / 1ps
`default_nettype none

module ita2enc_front (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_wr_en,
  input  wire logic [ita2enc_pkg::COUNT_W-1:0]     cfg_wr_data,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire ita2enc_pkg::in_item_t               in_data,
  input  wire logic                                q_full,
  output logic                                     q_push,
  output ita2enc_pkg::job_t                        q_job
);

  logic [ita2enc_pkg::COUNT_W-1:0] max_codes_r;
  logic [ita2enc_pkg::COUNT_W-1:0] cnt_r, cnt_nxt;
  ita2enc_pkg::shift_t             ts_r, ts_nxt;

  logic [6:0]                      ch;
  logic [7:0]                      ent;
  logic                            full;
  logic [1:0]                      n;
  logic [1:0]                      add;
  logic [ita2enc_pkg::COUNT_W:0]   sum;
  ita2enc_pkg::job_t               job;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign q_job    = job;

  always_comb begin
    ch     = in_data.ascii_char[6:0];
    ent    = ita2enc_pkg::ITA2_TAB[ch];
    if (ent[ita2enc_pkg::CLS_ESC_BIT]) begin
      ent = ita2enc_pkg::ESCAPE_SUBST;
    end
    full   = cnt_r >= max_codes_r;
    job    = '0;
    n      = 2'd0;
    add    = 2'd0;
    ts_nxt = ts_r;

    if (full) begin
      job.refused  = 1'b1;
      job.codes[0] = '0;
      n            = 2'd1;
    end else begin
      if (ent[ita2enc_pkg::CLS_LTRS_BIT] && ts_r != ita2enc_pkg::SHIFT_LTRS) begin
        job.codes[n] = ita2enc_pkg::rev5(ita2enc_pkg::LTRS_CODE);
        n            = n + 2'd1;
        add          = add + 2'd1;
        ts_nxt       = ita2enc_pkg::SHIFT_LTRS;
      end else if (ent[ita2enc_pkg::CLS_FIGS_BIT] && ts_r != ita2enc_pkg::SHIFT_FIGS) begin
        job.codes[n] = ita2enc_pkg::rev5(ita2enc_pkg::FIGS_CODE);
        n            = n + 2'd1;
        add          = add + 2'd1;
        ts_nxt       = ita2enc_pkg::SHIFT_FIGS;
      end
      job.codes[n] = ita2enc_pkg::rev5(ent[ita2enc_pkg::CODE_W-1:0]);
      n            = n + 2'd1;
      add          = add + 2'd1;
    end

    // saturating code count
    sum = {1'b0, cnt_r} + {{(ita2enc_pkg::COUNT_W-1){1'b0}}, add};
    if (sum > {1'b0, ita2enc_pkg::COUNT_MAX}) begin
      cnt_nxt = ita2enc_pkg::COUNT_MAX;
    end else begin
      cnt_nxt = sum[ita2enc_pkg::COUNT_W-1:0];
    end

    // end of write: restore receiver shift, then reopen the packet
    if (in_data.end_of_write) begin
      if (in_data.receive_shift == ita2enc_pkg::SHIFT_LTRS &&
          ts_nxt != ita2enc_pkg::SHIFT_LTRS) begin
        job.codes[n] = ita2enc_pkg::rev5(ita2enc_pkg::LTRS_CODE);
        n            = n + 2'd1;
      end else if (in_data.receive_shift == ita2enc_pkg::SHIFT_FIGS &&
                   ts_nxt != ita2enc_pkg::SHIFT_FIGS) begin
        job.codes[n] = ita2enc_pkg::rev5(ita2enc_pkg::FIGS_CODE);
        n            = n + 2'd1;
      end
      ts_nxt  = ita2enc_pkg::SHIFT_UNKNOWN;
      cnt_nxt = '0;
    end

    job.cnt = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_codes_r <= ita2enc_pkg::MAX_CODES_RST;
      cnt_r       <= '0;
      ts_r        <= ita2enc_pkg::SHIFT_UNKNOWN;
    end else begin
      if (cfg_wr_en) begin
        max_codes_r <= cfg_wr_data;
      end
      if (q_push) begin
        cnt_r <= cnt_nxt;
        ts_r  <= ts_nxt;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ita2enc_fifo.sv
// Short job queue between the front end and the output sequencer.
`timescale 1ns / 1ps
`default_nettype none

module ita2enc_fifo #(
  parameter int unsigned DEPTH = ita2enc_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire ita2enc_pkg::job_t wr_job,
  input  wire logic              pop,
  output ita2enc_pkg::job_t      rd_job,
  output logic                   full,
  output logic                   empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  ita2enc_pkg::job_t entries_r [DEPTH];
  logic [AW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]     count_r;

  assign full   = count_r == CW'(DEPTH);
  assign empty  = count_r == '0;
  assign rd_job = entries_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full || pop) else $error("job queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty) else $error("job queue underflow");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH)) else $error("job queue count out of range");

endmodule

`default_nettype wire

FILE: hw/rtl/ita2enc_back.sv
// Output sequencer: walks the head job one code per beat into the output register.
`timescale 1ns / 1ps
`default_nettype none

module ita2enc_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ita2enc_pkg::job_t head,
  input  wire logic              q_empty,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output ita2enc_pkg::out_item_t out_data
);

  logic                  out_valid_r;
  ita2enc_pkg::out_item_t out_r, out_nxt;
  logic [1:0]            idx_r;
  logic                  load;
  logic                  last_beat;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // output register refills whenever it is empty or being taken
  assign load      = !out_valid_r || !out_stall;
  assign last_beat = idx_r == (head.cnt - 2'd1);
  assign q_pop     = load && !q_empty && last_beat;

  always_comb begin
    out_nxt.code        = head.codes[idx_r];
    out_nxt.refused     = head.refused && idx_r == 2'd0;
    out_nxt.last_of_run = last_beat;
  end

  always_ff @(posedge clk) begin
    if (load && !q_empty) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (load) begin
      out_valid_r <= !q_empty;
      if (!q_empty) begin
        idx_r <= last_beat ? 2'd0 : idx_r + 2'd1;
      end
    end
  end

  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.refused |-> out_r.code == '0)
    else $error("refused beat carries a code");
  a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
    !q_empty |-> idx_r < head.cnt) else $error("beat index past end of job");
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && idx_r == '0) else $error("output not idle after reset");

endmodule

`default_nettype wire

FILE: hw/rtl/ascii_to_ita2_shift_encoder_unit.sv
// Top level of the ASCII to ITA2 shift encoder.
`timescale 1ns / 1ps
`default_nettype none

// Takes one ASCII character per beat and sends one to three bit-reversed ITA2 code
// beats: an optional letters/figures shift, the character code, and on end_of_write
// a code that restores the receiver's shift. A character arriving once the packet
// holds max_codes codes gives one refused beat. A character is taken every cycle
// while the job queue (QUEUE_DEPTH entries) has room; the output register sends one
// beat per cycle while out_stall is low. Each character's job is written into the
// queue and then loaded into the output register, which offers its first beat.
// max_codes is written through cfg_wr_en/cfg_wr_data and resets to 39.
module ascii_to_ita2_shift_encoder_unit #(
  parameter int unsigned QUEUE_DEPTH = ita2enc_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_wr_en,
  input  wire logic [ita2enc_pkg::COUNT_W-1:0] cfg_wr_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire ita2enc_pkg::in_item_t           in_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output ita2enc_pkg::out_item_t               out_data
);

  logic              q_push, q_pop, q_full, q_empty;
  ita2enc_pkg::job_t q_wr_job, q_rd_job;

  ita2enc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_job       (q_wr_job)
  );

  ita2enc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_job (q_wr_job),
    .pop    (q_pop),
    .rd_job (q_rd_job),
    .full   (q_full),
    .empty  (q_empty)
  );

  ita2enc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_rd_job),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
